### rtl/lpfl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpfl_pkg: shared types and constants of the LED panel frame loader
// Transaction payloads, frame store geometry, serial control bytes and the
// latch select codes used by the loader, frame store, scan sequencer and top.
// ----------------------------------------------------------------------------
package lpfl_pkg;

   localparam int unsigned STORE_BYTES = 90;
   localparam int unsigned ADDR_W      = 7;

   localparam logic [7:0] BYTE_RESET = 8'h81;
   localparam logic [7:0] BYTE_START = 8'h80;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Latch select codes for the two column latches.
   localparam logic [2:0] SEL_COL_LO = 3'd6;
   localparam logic [2:0] SEL_COL_HI = 3'd7;

   typedef struct packed {
      logic       operation;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] data_bits;
      logic [2:0] latch_select;
      logic       master_reset;
      logic       frame_last;
   } rsp_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } wr_type;

   // One scan step as decoded from the scan counters. For board row steps
   // the data comes from the frame store and data is unused.
   typedef struct packed {
      logic       is_row;
      logic [7:0] data;
      logic [2:0] sel;
      logic       mr;
      logic       last;
   } scan_step_type;

   typedef enum logic {
      LOAD_WAIT,
      LOAD_ACTIVE
   } load_state_type;

endpackage
`default_nettype wire

### rtl/led_panel_frame_loader_and_scanner_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// led_panel_frame_loader_and_scanner_top: LED panel frame loader and scanner
// Serial bytes load a 90-byte frame store; scan ticks step through the
// per-column latch write sequence and return one latch write each.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                          Direction  Payload
//   request   req_valid/req_ready/req_payload  in       lpfl_pkg::req_type
//   response  rsp_valid/rsp_ready/rsp_payload  out      lpfl_pkg::rsp_type
//
// One transaction is accepted per cycle. A scan tick shows its latch write on
// the response channel in the cycle after acceptance; the frame store read port
// and the response register form that single stage. Serial bytes give no
// response and are taken even while a response waits. A scan tick is held off
// only while the response register is full and the consumer is not ready.
// Reset is synchronous and clears the loader, scan counters, response valid
// and the store valid bits, so the store reads as zero until written.
// ----------------------------------------------------------------------------
module led_panel_frame_loader_and_scanner_top #(
   parameter int unsigned COLUMNS = 15,
   parameter int unsigned BOARDS  = 6
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire lpfl_pkg::req_type    req_payload,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output lpfl_pkg::rsp_type         rsp_payload
);

   logic                               rsp_valid_ff, rsp_valid_in;
   lpfl_pkg::scan_step_type            step_ff;
   lpfl_pkg::scan_step_type            step;
   lpfl_pkg::wr_type                   wr;
   logic [lpfl_pkg::ADDR_W-1:0]        rd_addr;
   logic                               rd_in_range;
   logic [7:0]                         rd_data;
   logic                               req_fire;
   logic                               byte_en;
   logic                               tick_en;

   // Bytes never produce a response, so they need no room in the response
   // register.
   assign req_ready = !rsp_valid_ff || rsp_ready ||
                      (req_payload.operation == lpfl_pkg::OP_BYTE);
   assign req_fire  = req_valid && req_ready;
   assign byte_en   = req_fire && (req_payload.operation == lpfl_pkg::OP_BYTE);
   assign tick_en   = req_fire && (req_payload.operation == lpfl_pkg::OP_TICK);

   lpfl_loader u_loader (
      .clock   (clock),
      .reset   (reset),
      .byte_en (byte_en),
      .rx_byte (req_payload.rx_byte),
      .wr      (wr)
   );

   lpfl_scan_seq #(
      .COLUMNS (COLUMNS),
      .BOARDS  (BOARDS)
   ) u_scan_seq (
      .clock       (clock),
      .reset       (reset),
      .advance     (tick_en),
      .step        (step),
      .rd_addr     (rd_addr),
      .rd_in_range (rd_in_range)
   );

   lpfl_frame_store u_frame_store (
      .clock       (clock),
      .reset       (reset),
      .wr          (wr),
      .rd_en       (tick_en),
      .rd_addr     (rd_addr),
      .rd_in_range (rd_in_range),
      .rd_data     (rd_data)
   );

   // Response register. The store read data is captured alongside it, in
   // the frame store, on the same edge.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (tick_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tick_en) begin
         step_ff <= step;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   // Row bytes are shifted left by one; bit 7 drops out.
   assign rsp_payload.data_bits    = step_ff.is_row ? {rd_data[6:0], 1'b0} : step_ff.data;
   assign rsp_payload.latch_select = step_ff.sel;
   assign rsp_payload.master_reset = step_ff.mr;
   assign rsp_payload.frame_last   = step_ff.last;

endmodule
`default_nettype wire

### rtl/lpfl_loader.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpfl_loader: serial byte loader
// Tracks the wait/load state and the write position, and turns accepted
// serial bytes into frame store writes.
// ----------------------------------------------------------------------------
module lpfl_loader (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      byte_en,
   input  wire logic [7:0]                rx_byte,
   output lpfl_pkg::wr_type               wr
);

   lpfl_pkg::load_state_type                state_ff, state_in;
   logic [lpfl_pkg::ADDR_W-1:0]             pos_ff, pos_in;
   logic [lpfl_pkg::ADDR_W-1:0]             pos_cur;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lpfl_pkg::LOAD_WAIT;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
      end
   end

   always_comb begin
      // A position past the end of the store is taken as the start.
      pos_cur  = (pos_ff >= lpfl_pkg::ADDR_W'(lpfl_pkg::STORE_BYTES)) ? '0 : pos_ff;
      state_in = state_ff;
      pos_in   = pos_ff;
      wr.en    = 1'b0;
      wr.addr  = pos_cur;
      wr.data  = rx_byte;
      if (byte_en) begin
         if (rx_byte == lpfl_pkg::BYTE_RESET) begin
            pos_in   = '0;
            state_in = lpfl_pkg::LOAD_WAIT;
         end else begin
            unique case (state_ff)
               lpfl_pkg::LOAD_ACTIVE: begin
                  wr.en  = 1'b1;
                  pos_in = (pos_cur == lpfl_pkg::ADDR_W'(lpfl_pkg::STORE_BYTES - 1))
                           ? '0 : pos_cur + 1'b1;
               end
               lpfl_pkg::LOAD_WAIT: begin
                  if (rx_byte == lpfl_pkg::BYTE_START) begin
                     state_in = lpfl_pkg::LOAD_ACTIVE;
                  end
               end
               default: begin
                  state_in = lpfl_pkg::LOAD_WAIT;
               end
            endcase
         end
      end
   end

endmodule
`default_nettype wire

### rtl/lpfl_frame_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpfl_frame_store: frame byte memory
// One write port and one registered read port. Per-entry valid bits make
// the store read as zero after reset until an entry is written.
// ----------------------------------------------------------------------------
module lpfl_frame_store (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire lpfl_pkg::wr_type            wr,
   input  wire logic                        rd_en,
   input  wire logic [lpfl_pkg::ADDR_W-1:0] rd_addr,
   input  wire logic                        rd_in_range,
   output logic [7:0]                       rd_data
);

   logic [7:0]                        mem [lpfl_pkg::STORE_BYTES];
   logic [lpfl_pkg::STORE_BYTES-1:0]  valid_ff;
   logic [7:0]                        rd_raw_ff;
   logic                              rd_ok_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_raw_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rd_ok_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_ok_ff <= rd_in_range && valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_ok_ff ? rd_raw_ff : 8'h00;

endmodule
`default_nettype wire

### rtl/lpfl_scan_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpfl_scan_seq: column scan sequencer
// Holds the column and step counters, decodes the current step into latch
// write fields and the frame store read address, and advances on each tick.
// ----------------------------------------------------------------------------
module lpfl_scan_seq #(
   parameter int unsigned COLUMNS = 15,
   parameter int unsigned BOARDS  = 6
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         advance,
   output lpfl_pkg::scan_step_type           step,
   output logic [lpfl_pkg::ADDR_W-1:0]       rd_addr,
   output logic                              rd_in_range
);

   localparam int unsigned STEPS = BOARDS + 3 + COLUMNS;

   logic [3:0] col_ff, col_in, col;
   logic [4:0] sub_ff, sub_in, sub;
   logic [4:0] k;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         sub_ff <= '0;
      end else begin
         col_ff <= col_in;
         sub_ff <= sub_in;
      end
   end

   always_comb begin
      col = ({1'b0, col_ff} >= 5'(COLUMNS)) ? '0 : col_ff;
      sub = (sub_ff >= 5'(STEPS)) ? '0 : sub_ff;
      k   = sub - 5'(BOARDS + 3);

      rd_addr     = lpfl_pkg::ADDR_W'(col) +
                    lpfl_pkg::ADDR_W'(COLUMNS) * lpfl_pkg::ADDR_W'(sub);
      rd_in_range = rd_addr < lpfl_pkg::ADDR_W'(lpfl_pkg::STORE_BYTES);

      step.is_row = 1'b0;
      step.data   = 8'h00;
      step.sel    = 3'd0;
      step.mr     = 1'b0;
      step.last   = (sub == 5'(STEPS - 1)) && ({1'b0, col} == 5'(COLUMNS - 1));

      priority if (sub < 5'(BOARDS)) begin
         step.is_row = 1'b1;
         step.sel    = sub[2:0];
      end else if (sub == 5'(BOARDS)) begin
         // Column select high write.
         step.data = {3'b000, col[2:0], 2'b10};
         step.sel  = col[3] ? lpfl_pkg::SEL_COL_HI : lpfl_pkg::SEL_COL_LO;
      end else if (sub == 5'(BOARDS + 1)) begin
         // Column select low write.
         step.data = {3'b000, col[2:0], 2'b00};
         step.sel  = col[3] ? lpfl_pkg::SEL_COL_HI : lpfl_pkg::SEL_COL_LO;
      end else if (sub == 5'(BOARDS + 2)) begin
         step.mr = 1'b1;
      end else begin
         // Column latch clear writes, one per column.
         step.data = {3'b000, k[2:0], 2'b10};
         step.sel  = (k[4:3] == 2'b00) ? lpfl_pkg::SEL_COL_LO : lpfl_pkg::SEL_COL_HI;
      end

      col_in = col_ff;
      sub_in = sub_ff;
      if (advance) begin
         if (sub == 5'(STEPS - 1)) begin
            sub_in = '0;
            col_in = ({1'b0, col} == 5'(COLUMNS - 1)) ? '0 : col + 1'b1;
         end else begin
            sub_in = sub + 1'b1;
            col_in = col;
         end
      end
   end

endmodule
`default_nettype wire
